### rtl/mhtm_pkg.sv
`default_nettype none

package mhtm_pkg;

    // Signature geometry, fixed by the widths of the item fields
    localparam int NUM_HASHES  = 64;
    localparam int MAX_ENTRIES = 1024;
    localparam int HASH_WIDTH_DEF = 64;

    localparam int POS_W  = $clog2(NUM_HASHES);
    localparam int ENT_W  = $clog2(MAX_ENTRIES);
    localparam int ADDR_W = ENT_W + POS_W;
    localparam int CNT_W  = $clog2(NUM_HASHES + 1);

    // Configuration registers
    localparam int THR_W      = 7;
    localparam int ECNT_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

    // Item operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        op;
        logic [9:0]  entry_index;
        logic [5:0]  hash_position;
        logic [63:0] hash_value;
        logic [15:0] query_tag;
    } mhtm_in_t;

    typedef struct packed {
        logic [15:0] result_tag;
        logic        match_found;
        logic [9:0]  match_index;
        logic [9:0]  best_index;
        logic [6:0]  best_count;
    } mhtm_out_t;

    // Controller to datapath
    typedef struct packed {
        logic ref_wr;
        logic tst_wr;
        logic start;
        logic issue;
        logic eval_en;
        logic load_out;
    } mhtm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic search_empty;
        logic issue_last;
        logic eval_end;
        logic out_free;
    } mhtm_stat_t;

endpackage

`default_nettype wire

### rtl/mhtm_ctrl.sv
`default_nettype none

module mhtm_ctrl
    import mhtm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire mhtm_in_t   s_data,
    input  wire mhtm_stat_t stat,
    output mhtm_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;
    logic       pos_ok;
    logic       idx_ok;
    logic       last_pos;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pos_ok   = int'(s_data.hash_position) < NUM_HASHES;
    assign idx_ok   = int'(s_data.entry_index) < MAX_ENTRIES;
    assign last_pos = int'(s_data.hash_position) == NUM_HASHES - 1;

    // Commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.ref_wr = accept && pos_ok && idx_ok && (s_data.op == OP_LOAD);
                cmd.tst_wr = accept && pos_ok && (s_data.op == OP_QUERY);
                cmd.start  = cmd.tst_wr && last_pos;
                if (cmd.start) begin
                    state_next = stat.search_empty ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.issue   = 1'b1;
                cmd.eval_en = 1'b1;
                if (stat.eval_end) begin
                    state_next = ST_FINISH;
                end else if (stat.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.eval_en = 1'b1;
                if (stat.eval_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.load_out = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mhtm_dpath.sv
`default_nettype none

module mhtm_dpath
    import mhtm_pkg::*;
#(
    parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire mhtm_in_t              s_data,
    input  wire mhtm_cmd_t             cmd,
    output mhtm_stat_t                 stat,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mhtm_out_t                  m_data
);

    localparam int MEM_DEPTH = MAX_ENTRIES * NUM_HASHES;

    // Configuration
    logic [THR_W-1:0]  thr_reg;
    logic [ECNT_W-1:0] ecnt_reg;
    logic [ECNT_W-1:0] limit;
    logic [ECNT_W-1:0] limit_m1;
    logic [ENT_W-1:0]  last_entry;

    // Storage
    logic [HASH_WIDTH-1:0] ref_mem [MEM_DEPTH];
    logic [HASH_WIDTH-1:0] tst_mem [NUM_HASHES];
    logic [HASH_WIDTH-1:0] ref_q_reg;
    logic [HASH_WIDTH-1:0] tst_q_reg;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    // Read issue
    logic [ENT_W-1:0] iss_ent_reg;
    logic [POS_W-1:0] iss_pos_reg;
    logic             iss_pos_wrap;

    // Compare stage
    logic             rd_valid_reg;
    logic             rd_first_reg;
    logic             rd_last_reg;
    logic [ENT_W-1:0] rd_ent_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] acc_next;
    logic             hash_eq;

    // Entry evaluation
    logic             fin_valid_reg;
    logic [CNT_W-1:0] fin_cnt_reg;
    logic [ENT_W-1:0] fin_ent_reg;
    logic             hit;

    // Running search result
    logic [15:0]      tag_reg;
    logic             found_reg;
    logic [ENT_W-1:0] match_idx_reg;
    logic [ENT_W-1:0] best_idx_reg;
    logic [CNT_W-1:0] best_cnt_reg;

    // Result register
    logic      m_valid_reg;
    mhtm_out_t m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_W'(48);
            ecnt_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_THRESHOLD:   thr_reg  <= cfg_wdata[THR_W-1:0];
                CFG_ENTRY_COUNT: ecnt_reg <= cfg_wdata[ECNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign limit      = (int'(ecnt_reg) > MAX_ENTRIES) ? ECNT_W'(MAX_ENTRIES) : ecnt_reg;
    assign limit_m1   = limit - ECNT_W'(1);
    assign last_entry = limit_m1[ENT_W-1:0];

    // Memories: one hash written and one read per cycle
    assign wr_addr = {s_data.entry_index[ENT_W-1:0], s_data.hash_position[POS_W-1:0]};
    assign rd_addr = {iss_ent_reg, iss_pos_reg};

    always_ff @(posedge aclk) begin
        if (cmd.ref_wr) begin
            ref_mem[wr_addr] <= s_data.hash_value[HASH_WIDTH-1:0];
        end
        ref_q_reg <= ref_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.tst_wr) begin
            tst_mem[s_data.hash_position[POS_W-1:0]] <= s_data.hash_value[HASH_WIDTH-1:0];
        end
        tst_q_reg <= tst_mem[iss_pos_reg];
    end

    // Read address walk: positions within an entry, entries ascending
    assign iss_pos_wrap = int'(iss_pos_reg) == NUM_HASHES - 1;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            iss_ent_reg <= '0;
            iss_pos_reg <= '0;
        end else if (cmd.issue) begin
            if (iss_pos_wrap) begin
                iss_pos_reg <= '0;
                iss_ent_reg <= iss_ent_reg + ENT_W'(1);
            end else begin
                iss_pos_reg <= iss_pos_reg + POS_W'(1);
            end
        end
    end

    // Tags that travel with the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue && !cmd.start;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg <= (iss_pos_reg == '0);
        rd_last_reg  <= iss_pos_wrap;
        rd_ent_reg   <= iss_ent_reg;
    end

    // Count equal positions of one entry
    assign hash_eq  = (ref_q_reg == tst_q_reg);
    assign acc_next = (rd_first_reg ? '0 : acc_reg) + CNT_W'(hash_eq);

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else begin
            fin_valid_reg <= rd_valid_reg && rd_last_reg && !cmd.start;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && rd_last_reg) begin
            fin_cnt_reg <= acc_next;
            fin_ent_reg <= rd_ent_reg;
        end
    end

    // Evaluate a finished entry against best and threshold
    assign hit = (THR_W'(fin_cnt_reg) >= thr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            tag_reg       <= s_data.query_tag;
            found_reg     <= 1'b0;
            match_idx_reg <= '0;
            best_idx_reg  <= '0;
            best_cnt_reg  <= '0;
        end else if (cmd.eval_en && fin_valid_reg) begin
            if (fin_cnt_reg > best_cnt_reg) begin
                best_cnt_reg <= fin_cnt_reg;
                best_idx_reg <= fin_ent_reg;
            end
            if (hit) begin
                found_reg     <= 1'b1;
                match_idx_reg <= fin_ent_reg;
            end
        end
    end

    // Result register, free when empty or being taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.result_tag  <= tag_reg;
            m_data_reg.match_found <= found_reg;
            m_data_reg.match_index <= 10'(match_idx_reg);
            m_data_reg.best_index  <= 10'(best_idx_reg);
            m_data_reg.best_count  <= 7'(best_cnt_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status to the controller
    assign stat.search_empty = (thr_reg == '0) || (limit == '0);
    assign stat.issue_last   = (iss_ent_reg == last_entry) && iss_pos_wrap;
    assign stat.eval_end     = fin_valid_reg && (hit || (fin_ent_reg == last_entry));
    assign stat.out_free     = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

### rtl/minhash_threshold_match_search.sv
// MinHash threshold match search.
// Input channel (s_valid/s_ready/s_data): load items write one reference hash,
// query items write one test-signature hash; the channel takes one transfer per
// cycle while no search runs.
// The query item at the last hash position starts a search that compares the
// test signature with entries 0 .. entry_count-1, one hash per cycle through
// the single read port of the reference memory; it stops after the first entry
// whose count reaches threshold_count (entry_count is capped at 1024). The
// result is loaded once the last entry visited has passed the read, compare
// and evaluation registers, or directly when the threshold or the entry count
// is zero, and only when the result register is free; s_ready is low until then.
// Result channel (m_valid/m_ready/m_data): one transfer per search, held in an
// output register; while it waits for m_ready, loads and queries are still
// taken, and only the end of the next search waits for the register to free.
// Configuration (cfg_we/cfg_index/cfg_wdata) is written by the user only while
// no item is in flight; the block does not enforce this. Synchronous active-low
// reset clears the controller, result register and configuration (threshold 48,
// entry count 0); memory is not cleared and reads unknown until written.
`default_nettype none

module minhash_threshold_match_search
    import mhtm_pkg::*;
#(
    parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire mhtm_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mhtm_out_t                  m_data
);

    mhtm_cmd_t  cmd;
    mhtm_stat_t stat;

    mhtm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .stat    (stat),
        .cmd     (cmd)
    );

    mhtm_dpath #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
